// ===== hw/rtl/yfr_pkg.sv =====
// shared types and constants of the yuv 4:2:0 frame rotator
`default_nettype none

package yfr_pkg;

  localparam int CFG_W = 10;
  localparam int PIX_W = 8;
  localparam int ROT_W = 2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROTATION     = 2'd2;

  // rotation codes, clockwise
  localparam logic [ROT_W-1:0] ROT_90  = 2'd0;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd1;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd2;

  typedef enum logic [1:0] {
    PLANE_Y,
    PLANE_U,
    PLANE_V,
    PLANE_DONE
  } plane_t;

  typedef enum logic [1:0] {
    ST_CALC,
    ST_INIT,
    ST_IDLE,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [ROT_W-1:0] rotation;
  } cfg_t;

  typedef struct packed {
    logic init;
    logic load;
    logic drain;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic frame_empty;
    logic loader_done;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/yuv420_frame_rotator_core.sv =====
// load byte: one accepted per cycle while item_stall is low; the write goes to the rotated address at once
// drain byte: registered store read, then the word is captured into the result; no input is taken until that capture
// reset and every register write: setup states CALC (plane size multiply) and INIT (counter init), stall high
// frame store is not cleared: bytes of a frame that was never loaded read back undefined
`default_nettype none

module yuv420_frame_rotator_core
  import yfr_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  stat_t      stat;
  logic [1:0] reg_index;
  logic       cfg_write, cfg_restart;

  assign pready      = 1'b1;
  assign reg_index   = paddr[3:2];
  assign cfg_write   = psel && penable && pwrite && pready;
  assign cfg_restart = cfg_write && ((reg_index == REG_FRAME_WIDTH) ||
                                     (reg_index == REG_FRAME_HEIGHT) ||
                                     (reg_index == REG_ROTATION));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= CFG_W'(352);
      cfg.frame_height <= CFG_W'(288);
      cfg.rotation     <= ROT_90;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[CFG_W-1:0];
        REG_ROTATION:     cfg.rotation     <= pwdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_FRAME_WIDTH:  prdata = 32'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(cfg.frame_height);
      REG_ROTATION:     prdata = 32'(cfg.rotation);
      default:          prdata = '0;
    endcase
  end

  yfr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_restart  (cfg_restart),
    .item_valid   (item_valid),
    .item_kind    (item.kind),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  yfr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .pixel_in (item.pixel_in),
    .stat     (stat),
    .result   (result)
  );

  // a register write always forces the setup sequence
  a_restart_stalls: assert property (@(posedge clk) disable iff (rst)
    cfg_restart |=> item_stall)
    else $error("input taken right after a register write");

  // a drain holds off the next word until its store read is done
  a_drain_stalls: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.kind) |=> item_stall)
    else $error("input taken while a drain read is in flight");

  // store write and drain read never share a cycle
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.drain && !cmd.capture)
    else $error("store write collides with a drain");

endmodule

`default_nettype wire

// ===== hw/rtl/yfr_ram.sv =====
// generic single-clock ram, one write port, one registered read port
`default_nettype none

module yfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/yfr_ctrl.sv =====
// controller: setup sequencing, input handshake, drain fetch and output valid
`default_nettype none

module yfr_ctrl
  import yfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_restart,
  input  wire logic item_valid,
  input  wire logic item_kind,
  output logic      item_stall,
  output logic      result_valid,
  input  wire logic result_stall,
  input  wire stat_t stat,
  output cmd_t      cmd
);

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign item_stall = (state != ST_IDLE) || cfg_restart;
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    if (cfg_restart) begin
      state_next = ST_CALC;
    end else begin
      unique case (state)
        ST_CALC:  state_next = ST_INIT;
        ST_INIT:  state_next = ST_IDLE;
        ST_IDLE:  if (accept && item_kind) state_next = ST_FETCH;
        ST_FETCH: if (out_free) state_next = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.init    = (state == ST_INIT);
    cmd.load    = accept && !item_kind && !stat.frame_empty && !stat.loader_done;
    cmd.drain   = accept && item_kind;
    cmd.capture = (state == ST_FETCH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CALC;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/yfr_datapath.sv =====
// datapath: rotated write address counters, drain counter, frame store, output word
`default_nettype none

module yfr_datapath
  import yfr_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire cmd_t             cmd,
  input  wire logic [PIX_W-1:0] pixel_in,
  output stat_t                 stat,
  output result_t               result
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0]   w_clamp, h_clamp, w_eff, h_eff;
  logic [2*CFG_W-1:0] prod_full;
  logic [ADDR_W-1:0]  ysize, csize, total;
  logic               empty;

  // loader state
  plane_t             plane;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [ADDR_W-1:0]  addr, row_addr;

  // drain state
  logic [ADDR_W-1:0]  daddr;
  logic               pend_last, pend_empty;
  logic [PIX_W-1:0]   rdata;

  logic               drain_last, restart;
  plane_t             tgt_plane;
  logic [CFG_W-1:0]   tgt_ph, cur_pw, cur_ph;
  logic [ADDR_W-1:0]  tgt_base, tgt_size, tgt_ph_a, tgt_start, cur_ph_a;
  logic               end_col, end_row;

  always_comb begin
    w_clamp = cfg.frame_width;
    h_clamp = cfg.frame_height;
    if (32'(cfg.frame_width) > MAX_WIDTH) w_clamp = CFG_W'(MAX_WIDTH);
    if (32'(cfg.frame_height) > MAX_HEIGHT) h_clamp = CFG_W'(MAX_HEIGHT);
    w_eff = {w_clamp[CFG_W-1:1], 1'b0};
    h_eff = {h_clamp[CFG_W-1:1], 1'b0};
  end

  assign empty     = (w_eff == '0) || (h_eff == '0);
  assign prod_full = (2*CFG_W)'(w_eff) * (2*CFG_W)'(h_eff);

  // luma plane size, registered every cycle; settles during the setup state
  always_ff @(posedge clk) begin
    ysize <= ADDR_W'(prod_full);
  end

  assign csize = ysize >> 2;
  assign total = ysize + (ysize >> 1);

  assign drain_last = empty || (daddr == total - 1'b1);
  assign restart    = cmd.init || (cmd.drain && drain_last);
  assign tgt_plane  = restart ? PLANE_Y : plane_t'(plane + 2'd1);

  // first write address of the plane the loader moves to
  always_comb begin
    tgt_ph   = h_eff >> 1;
    tgt_base = ysize + csize;
    tgt_size = csize;
    unique case (tgt_plane)
      PLANE_Y: begin
        tgt_ph   = h_eff;
        tgt_base = '0;
        tgt_size = ysize;
      end
      PLANE_U: tgt_base = ysize;
      default: tgt_base = ysize + csize;
    endcase
    tgt_ph_a = ADDR_W'(tgt_ph);
    unique case (cfg.rotation)
      ROT_90:  tgt_start = tgt_base + tgt_ph_a - 1'b1;
      ROT_180: tgt_start = tgt_base + tgt_size - 1'b1;
      ROT_270: tgt_start = tgt_base + (tgt_size - tgt_ph_a);
      default: tgt_start = tgt_base;
    endcase
  end

  always_comb begin
    cur_pw   = (plane == PLANE_Y) ? w_eff : (w_eff >> 1);
    cur_ph   = (plane == PLANE_Y) ? h_eff : (h_eff >> 1);
    cur_ph_a = ADDR_W'(cur_ph);
    end_col  = (CFG_W'(col) == cur_pw - 1'b1);
    end_row  = (CFG_W'(row) == cur_ph - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane    <= PLANE_Y;
      col      <= '0;
      row      <= '0;
      addr     <= '0;
      row_addr <= '0;
    end else begin
      priority if (restart) begin
        plane    <= PLANE_Y;
        col      <= '0;
        row      <= '0;
        addr     <= tgt_start;
        row_addr <= tgt_start;
      end else if (cmd.load) begin
        if (end_col) begin
          col <= '0;
          if (end_row) begin
            row      <= '0;
            plane    <= tgt_plane;
            addr     <= tgt_start;
            row_addr <= tgt_start;
          end else begin
            row <= row + 1'b1;
            unique case (cfg.rotation)
              ROT_90: begin
                row_addr <= row_addr - 1'b1;
                addr     <= row_addr - 1'b1;
              end
              ROT_180: addr <= addr - 1'b1;
              ROT_270: begin
                row_addr <= row_addr + 1'b1;
                addr     <= row_addr + 1'b1;
              end
              default: addr <= addr + 1'b1;
            endcase
          end
        end else begin
          col <= col + 1'b1;
          unique case (cfg.rotation)
            ROT_90:  addr <= addr + cur_ph_a;
            ROT_180: addr <= addr - 1'b1;
            ROT_270: addr <= addr - cur_ph_a;
            default: addr <= addr + 1'b1;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      daddr <= '0;
    end else if (cmd.init || (cmd.drain && drain_last)) begin
      daddr <= '0;
    end else if (cmd.drain) begin
      daddr <= daddr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain) begin
      pend_last  <= drain_last;
      pend_empty <= empty;
    end
    if (cmd.capture) begin
      result.pixel_out <= pend_empty ? '0 : rdata;
      result.last      <= pend_last;
    end
  end

  yfr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (addr),
    .wdata (pixel_in),
    .re    (cmd.drain),
    .raddr (daddr),
    .rdata (rdata)
  );

  assign stat.frame_empty = empty;
  assign stat.loader_done = (plane == PLANE_DONE);

endmodule

`default_nettype wire
